// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: src/evr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package evr_pkg;
	localparam int COMP_WIDTH_DEF  = 16;
	localparam int ANGLE_WIDTH_DEF = 16;
	localparam int PHASE_W         = 32;
	localparam int CRD_W           = 33;
	localparam int TRIG_W          = 16;
	localparam int RND_SHIFT       = 15;
	localparam int CORDIC_STEPS    = 24;
	localparam int ITERS_PER_STAGE = 2;
	localparam int CORDIC_STAGES   = CORDIC_STEPS / ITERS_PER_STAGE;
	localparam int CORDIC_LAT      = CORDIC_STAGES + 2;
	localparam int ROT_LAT         = 7;
	localparam int PIPE_LAT        = CORDIC_LAT + ROT_LAT;

	localparam logic signed [CRD_W-1:0]  X_INIT   = 33'sh026DD3B6A;
	localparam logic signed [TRIG_W-1:0] TRIG_MAX = 16'sh7FFF;
	localparam logic signed [TRIG_W-1:0] TRIG_MIN = -16'sh7FFF;

	localparam logic [PHASE_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef logic signed [TRIG_W-1:0] trig_t;

	typedef struct packed {
		trig_t c;
		trig_t s;
	} sincos_t;
endpackage
`default_nettype wire

// File: src/euler_xyz_vector_rotate_unit.sv
// throughput: one vector per cycle while the output is not stalled; stalls collapse bubbles stage by stage
// angle path: 24-step cordic at two steps per stage, three lanes in parallel
// reset: arst_n clears all stage valid bits asynchronously; data regs are not reset
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module euler_xyz_vector_rotate_unit
	import evr_pkg::*;
#(
	parameter int COMP_WIDTH  = COMP_WIDTH_DEF,
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          vec_valid,
	output logic                               vec_stall,
	input  wire logic signed [COMP_WIDTH-1:0]  vec_x,
	input  wire logic signed [COMP_WIDTH-1:0]  vec_y,
	input  wire logic signed [COMP_WIDTH-1:0]  vec_z,
	input  wire logic [ANGLE_WIDTH-1:0]        angle_about_x,
	input  wire logic [ANGLE_WIDTH-1:0]        angle_about_y,
	input  wire logic [ANGLE_WIDTH-1:0]        angle_about_z,
	output logic                               rot_valid,
	input  wire logic                          rot_stall,
	output logic signed [COMP_WIDTH-1:0]       rot_x,
	output logic signed [COMP_WIDTH-1:0]       rot_y,
	output logic signed [COMP_WIDTH-1:0]       rot_z,
	output logic                               saturated
);
	localparam logic signed [COMP_WIDTH-1:0] CMAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
	localparam logic signed [COMP_WIDTH-1:0] CMIN = ~CMAX;

	logic [PIPE_LAT-1:0] vld_q;
	logic [PIPE_LAT-1:0] ld;
	sincos_t             trig_x, trig_y, trig_z;

	// a stage loads unless it and every stage after it hold an item and the output stalls
	for (genvar k = 0; k < PIPE_LAT; k++) begin : g_ld
		assign ld[k] = !(rot_stall && (&vld_q[PIPE_LAT-1:k]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[0])
				vld_q[0] <= vec_valid;
			for (int k = 1; k < PIPE_LAT; k++) begin
				if (ld[k])
					vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign vec_stall = !ld[0];
	assign rot_valid = vld_q[PIPE_LAT-1];

	evr_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic_x (
		.clk(clk), .ld(ld[CORDIC_LAT-1:0]), .angle(angle_about_x), .trig(trig_x)
	);
	evr_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic_y (
		.clk(clk), .ld(ld[CORDIC_LAT-1:0]), .angle(angle_about_y), .trig(trig_y)
	);
	evr_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic_z (
		.clk(clk), .ld(ld[CORDIC_LAT-1:0]), .angle(angle_about_z), .trig(trig_z)
	);

	evr_rotate #(.COMP_WIDTH(COMP_WIDTH)) u_rotate (
		.clk(clk),
		.ld(ld),
		.vec_x(vec_x),
		.vec_y(vec_y),
		.vec_z(vec_z),
		.trig_x(trig_x),
		.trig_y(trig_y),
		.trig_z(trig_z),
		.rot_x(rot_x),
		.rot_y(rot_y),
		.rot_z(rot_z),
		.saturated(saturated)
	);

	`ASSERT_CLK(a_stall_only_when_full, clk, arst_n, vec_stall |-> (&vld_q), "input stalled with a free stage")
	`ASSERT_NEXT(a_drain_bubble, clk, arst_n, rot_valid && !rot_stall && !vld_q[PIPE_LAT-2], !rot_valid, "output repeated after transfer")
	`ASSERT_CLK(a_sat_at_limit, clk, arst_n, (rot_valid && saturated) |-> (rot_x == CMAX || rot_x == CMIN || rot_y == CMAX || rot_y == CMIN || rot_z == CMAX || rot_z == CMIN), "saturated without a clipped component")
endmodule
`default_nettype wire

// File: src/evr_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module evr_cordic
	import evr_pkg::*;
#(
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic [CORDIC_LAT-1:0] ld,
	input  wire logic [ANGLE_WIDTH-1:0] angle,
	output sincos_t                    trig
);
	localparam int RW = CRD_W - RND_SHIFT;

	logic signed [CRD_W-1:0]   x_s    [CORDIC_STAGES+1];
	logic signed [CRD_W-1:0]   y_s    [CORDIC_STAGES+1];
	logic signed [PHASE_W-1:0] z_s    [CORDIC_STAGES+1];
	logic                      flip_s [CORDIC_STAGES+1];
	logic [PHASE_W-1:0]        phase;

	assign phase = {angle, {(PHASE_W-ANGLE_WIDTH){1'b0}}};

	// quadrant fold: second and third quadrant turned by a half turn
	always_ff @(posedge clk) begin
		if (ld[0]) begin
			x_s[0]    <= X_INIT;
			y_s[0]    <= '0;
			z_s[0]    <= signed'({phase[PHASE_W-2], phase[PHASE_W-2:0]});
			flip_s[0] <= phase[PHASE_W-1] ^ phase[PHASE_W-2];
		end
	end

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
		logic signed [CRD_W-1:0]   xa [ITERS_PER_STAGE+1];
		logic signed [CRD_W-1:0]   ya [ITERS_PER_STAGE+1];
		logic signed [PHASE_W-1:0] za [ITERS_PER_STAGE+1];

		always_comb begin
			xa[0] = x_s[g];
			ya[0] = y_s[g];
			za[0] = z_s[g];
			for (int j = 0; j < ITERS_PER_STAGE; j++) begin
				if (za[j] >= 0) begin
					xa[j+1] = xa[j] - (ya[j] >>> (g*ITERS_PER_STAGE + j));
					ya[j+1] = ya[j] + (xa[j] >>> (g*ITERS_PER_STAGE + j));
					za[j+1] = za[j] - signed'(ATAN_TAB[g*ITERS_PER_STAGE + j]);
				end else begin
					xa[j+1] = xa[j] + (ya[j] >>> (g*ITERS_PER_STAGE + j));
					ya[j+1] = ya[j] - (xa[j] >>> (g*ITERS_PER_STAGE + j));
					za[j+1] = za[j] + signed'(ATAN_TAB[g*ITERS_PER_STAGE + j]);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (ld[g+1]) begin
				x_s[g+1]    <= xa[ITERS_PER_STAGE];
				y_s[g+1]    <= ya[ITERS_PER_STAGE];
				z_s[g+1]    <= za[ITERS_PER_STAGE];
				flip_s[g+1] <= flip_s[g];
			end
		end
	end

	function automatic trig_t clamp_trig(input logic signed [RW-1:0] v);
		if (v > RW'(TRIG_MAX))
			return TRIG_MAX;
		else if (v < RW'(TRIG_MIN))
			return TRIG_MIN;
		else
			return trig_t'(v);
	endfunction

	logic signed [CRD_W-1:0] xn, yn, xt, yt;

	// undo the fold, round half up to q1.15
	always_comb begin
		xn = flip_s[CORDIC_STAGES] ? -x_s[CORDIC_STAGES] : x_s[CORDIC_STAGES];
		yn = flip_s[CORDIC_STAGES] ? -y_s[CORDIC_STAGES] : y_s[CORDIC_STAGES];
		xt = xn + (CRD_W'(1) <<< (RND_SHIFT-1));
		yt = yn + (CRD_W'(1) <<< (RND_SHIFT-1));
	end

	always_ff @(posedge clk) begin
		if (ld[CORDIC_LAT-1]) begin
			trig.c <= clamp_trig(xt[CRD_W-1:RND_SHIFT]);
			trig.s <= clamp_trig(yt[CRD_W-1:RND_SHIFT]);
		end
	end
endmodule
`default_nettype wire

// File: src/evr_rotate.sv
`timescale 1ns / 1ps
`default_nettype none
module evr_rotate
	import evr_pkg::*;
#(
	parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic [PIPE_LAT-1:0]          ld,
	input  wire logic signed [COMP_WIDTH-1:0] vec_x,
	input  wire logic signed [COMP_WIDTH-1:0] vec_y,
	input  wire logic signed [COMP_WIDTH-1:0] vec_z,
	input  wire sincos_t                      trig_x,
	input  wire sincos_t                      trig_y,
	input  wire sincos_t                      trig_z,
	output logic signed [COMP_WIDTH-1:0]      rot_x,
	output logic signed [COMP_WIDTH-1:0]      rot_y,
	output logic signed [COMP_WIDTH-1:0]      rot_z,
	output logic                              saturated
);
	localparam int IW = COMP_WIDTH + 2;
	localparam int PW = IW + TRIG_W;
	localparam int SW = PW + 1;
	localparam logic signed [COMP_WIDTH-1:0] CMAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
	localparam logic signed [COMP_WIDTH-1:0] CMIN = ~CMAX;

	typedef logic signed [IW-1:0] comp_t;
	typedef logic signed [PW-1:0] prod_t;

	function automatic prod_t mul(input comp_t a, input trig_t b);
		return PW'(a) * PW'(b);
	endfunction

	function automatic comp_t rnd(input prod_t a, input prod_t b, input logic sub);
		logic signed [SW-1:0] t;
		t = (sub ? SW'(a) - SW'(b) : SW'(a) + SW'(b)) + (SW'(1) <<< (RND_SHIFT-1));
		return comp_t'(t >>> RND_SHIFT);
	endfunction

	function automatic logic [1:0] over(input comp_t v);
		return {v > IW'(CMAX), v < IW'(CMIN)};
	endfunction

	function automatic logic signed [COMP_WIDTH-1:0] clip(input comp_t v);
		if (v > IW'(CMAX))
			return CMAX;
		else if (v < IW'(CMIN))
			return CMIN;
		else
			return COMP_WIDTH'(v);
	endfunction

	// vector waits alongside the angle pipeline
	comp_t vx_s [CORDIC_LAT];
	comp_t vy_s [CORDIC_LAT];
	comp_t vz_s [CORDIC_LAT];

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			vx_s[0] <= IW'(vec_x);
			vy_s[0] <= IW'(vec_y);
			vz_s[0] <= IW'(vec_z);
		end
		for (int k = 1; k < CORDIC_LAT; k++) begin
			if (ld[k]) begin
				vx_s[k] <= vx_s[k-1];
				vy_s[k] <= vy_s[k-1];
				vz_s[k] <= vz_s[k-1];
			end
		end
	end

	prod_t   p0_s15, p1_s15, p2_s15, p3_s15;
	comp_t   x_s15, y_s16, z_s16, x_s16;
	sincos_t ty_s15, tz_s15, ty_s16, tz_s16, tz_s17, tz_s18;
	prod_t   p0_s17, p1_s17, p2_s17, p3_s17;
	comp_t   y_s17, x_s18, z_s18, y_s18;
	prod_t   p0_s19, p1_s19, p2_s19, p3_s19;
	comp_t   z_s19, x_s20, y_s20, z_s20;

	always_ff @(posedge clk) begin
		// about x
		if (ld[CORDIC_LAT]) begin
			p0_s15 <= mul(vy_s[CORDIC_LAT-1], trig_x.c);
			p1_s15 <= mul(vz_s[CORDIC_LAT-1], trig_x.s);
			p2_s15 <= mul(vy_s[CORDIC_LAT-1], trig_x.s);
			p3_s15 <= mul(vz_s[CORDIC_LAT-1], trig_x.c);
			x_s15  <= vx_s[CORDIC_LAT-1];
			ty_s15 <= trig_y;
			tz_s15 <= trig_z;
		end
		if (ld[CORDIC_LAT+1]) begin
			y_s16  <= rnd(p0_s15, p1_s15, 1'b1);
			z_s16  <= rnd(p2_s15, p3_s15, 1'b0);
			x_s16  <= x_s15;
			ty_s16 <= ty_s15;
			tz_s16 <= tz_s15;
		end
		// about y
		if (ld[CORDIC_LAT+2]) begin
			p0_s17 <= mul(x_s16, ty_s16.c);
			p1_s17 <= mul(z_s16, ty_s16.s);
			p2_s17 <= mul(z_s16, ty_s16.c);
			p3_s17 <= mul(x_s16, ty_s16.s);
			y_s17  <= y_s16;
			tz_s17 <= tz_s16;
		end
		if (ld[CORDIC_LAT+3]) begin
			x_s18  <= rnd(p0_s17, p1_s17, 1'b0);
			z_s18  <= rnd(p2_s17, p3_s17, 1'b1);
			y_s18  <= y_s17;
			tz_s18 <= tz_s17;
		end
		// about z
		if (ld[CORDIC_LAT+4]) begin
			p0_s19 <= mul(x_s18, tz_s18.c);
			p1_s19 <= mul(y_s18, tz_s18.s);
			p2_s19 <= mul(x_s18, tz_s18.s);
			p3_s19 <= mul(y_s18, tz_s18.c);
			z_s19  <= z_s18;
		end
		if (ld[CORDIC_LAT+5]) begin
			x_s20 <= rnd(p0_s19, p1_s19, 1'b1);
			y_s20 <= rnd(p2_s19, p3_s19, 1'b0);
			z_s20 <= z_s19;
		end
		if (ld[CORDIC_LAT+6]) begin
			rot_x     <= clip(x_s20);
			rot_y     <= clip(y_s20);
			rot_z     <= clip(z_s20);
			saturated <= |{over(x_s20), over(y_s20), over(z_s20)};
		end
	end
endmodule
`default_nettype wire
